@@ design/cmu8d_pkg.sv @@
// Shared types and codes for the chunked modified UTF-8 string decoder.
package cmu8d_pkg;

  localparam logic [2:0] PH_NULL = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_CLEN = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_DROP = 3'd4;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_NULL  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  header_byte_index;
    logic [31:0] length_shift;
    logic [15:0] chunk_bytes_left;
    logic [15:0] partial_unit;
    logic [1:0]  continuations_needed;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] code_unit;
    logic [1:0]  kind;
    logic        last;
  } result_t;

endpackage

@@ design/cmu8d_step.sv @@
// Next-state and result logic for one input byte.
module cmu8d_step #(
  parameter int CHUNK_SIZE = 16384
) (
  input  cmu8d_pkg::state_t  st,
  input  logic [7:0]         data_byte,
  output cmu8d_pkg::state_t  st_next,
  output cmu8d_pkg::result_t res
);
  import cmu8d_pkg::*;

  localparam logic signed [33:0] LIM_BAD   = 34'(-2 * CHUNK_SIZE);
  localparam logic signed [33:0] LIM_EMPTY = 34'(-CHUNK_SIZE);
  localparam logic [32:0]        CHUNK_LEN = 33'(CHUNK_SIZE);

  logic [15:0]        cbl_dec;
  logic [31:0]        len_n;
  logic signed [33:0] len_ext;
  logic [15:0]        cbl_n;
  logic [1:0]         cont_n;
  logic [15:0]        part_n;
  logic               have;
  logic               bad;
  logic               end_now;
  logic [15:0]        unit;
  logic [1:0]         kind_w;
  logic               last_w;

  always_comb begin
    cbl_dec = (st.chunk_bytes_left != '0) ? st.chunk_bytes_left - 16'd1 : '0;
    len_n   = {st.length_shift[23:0], data_byte};
    len_ext = 34'($signed(len_n));
    cbl_n   = {st.chunk_bytes_left[7:0], data_byte};
    cont_n  = st.continuations_needed - 2'd1;
    part_n  = st.partial_unit | (cont_n[0] ? {4'd0, data_byte[5:0], 6'd0}
                                           : {10'd0, data_byte[5:0]});
  end

  always_comb begin
    st_next = st;
    have    = 1'b0;
    bad     = 1'b0;
    end_now = 1'b0;
    unit    = '0;
    kind_w  = KIND_CHAR;
    last_w  = 1'b0;
    unique case (st.phase)
      PH_LEN: begin
        st_next.length_shift      = len_n;
        st_next.header_byte_index = st.header_byte_index + 2'd1;
        if (st.header_byte_index == 2'd3) begin
          st_next.header_byte_index = '0;
          if (len_ext <= LIM_BAD) begin
            st_next.phase = PH_NULL;
            have   = 1'b1;
            kind_w = KIND_BAD;
            last_w = 1'b1;
          end else if (len_ext <= LIM_EMPTY) begin
            st_next.phase = PH_NULL;
            have   = 1'b1;
            kind_w = KIND_EMPTY;
            last_w = 1'b1;
          end else begin
            st_next.length_shift     = len_n[31] ? '0 : len_n;
            st_next.chunk_bytes_left = '0;
            st_next.phase            = PH_CLEN;
          end
        end
      end
      PH_CLEN: begin
        st_next.chunk_bytes_left  = cbl_n;
        st_next.header_byte_index = st.header_byte_index + 2'd1;
        if (st.header_byte_index != 2'd0) begin
          st_next.header_byte_index    = '0;
          st_next.continuations_needed = '0;
          st_next.partial_unit         = '0;
          if (cbl_n == '0) begin
            end_now = 1'b1;
          end else begin
            st_next.phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        st_next.chunk_bytes_left = cbl_dec;
        if (st.continuations_needed == 2'd0) begin
          if (!data_byte[7]) begin
            have = 1'b1;
            unit = {8'd0, data_byte};
          end else if (data_byte[7:5] == 3'b110) begin
            if (cbl_dec == '0) begin
              bad = 1'b1;
            end else begin
              st_next.partial_unit         = {5'd0, data_byte[4:0], 6'd0};
              st_next.continuations_needed = 2'd1;
            end
          end else if (data_byte[7:4] == 4'b1110) begin
            if (cbl_dec < 16'd2) begin
              bad = 1'b1;
            end else begin
              st_next.partial_unit         = {data_byte[3:0], 12'd0};
              st_next.continuations_needed = 2'd2;
            end
          end else begin
            bad = 1'b1;
          end
        end else if (data_byte[7:6] != 2'b10) begin
          bad = 1'b1;
        end else begin
          st_next.continuations_needed = cont_n;
          st_next.partial_unit         = part_n;
          if (cont_n == 2'd0) begin
            have = 1'b1;
            unit = part_n;
          end
        end
        if (bad) begin
          have   = 1'b1;
          unit   = '0;
          kind_w = KIND_BAD;
          st_next.continuations_needed = '0;
          st_next.partial_unit         = '0;
          if (cbl_dec != '0) begin
            st_next.phase = PH_DROP;
          end
        end
        end_now = (cbl_dec == '0);
      end
      PH_DROP: begin
        st_next.chunk_bytes_left = cbl_dec;
        end_now = (cbl_dec == '0);
      end
      default: begin
        if (data_byte != 8'd0) begin
          st_next.phase = PH_NULL;
          have   = 1'b1;
          kind_w = KIND_NULL;
          last_w = 1'b1;
        end else begin
          st_next.phase             = PH_LEN;
          st_next.header_byte_index = '0;
          st_next.length_shift      = '0;
        end
      end
    endcase

    if (end_now) begin
      if ({1'b0, st.length_shift} < CHUNK_LEN) begin
        st_next.phase = PH_NULL;
        last_w = 1'b1;
        if (!have) begin
          have   = 1'b1;
          unit   = '0;
          kind_w = KIND_EMPTY;
        end
      end else begin
        st_next.length_shift      = st.length_shift - CHUNK_LEN[31:0];
        st_next.phase             = PH_CLEN;
        st_next.header_byte_index = '0;
        st_next.chunk_bytes_left  = '0;
      end
    end

    res.valid     = have;
    res.code_unit = unit;
    res.kind      = kind_w;
    res.last      = last_w;
  end

endmodule

@@ design/cmu8d_outreg.sv @@
// Result register between the decode logic and the result channel.
module cmu8d_outreg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  cmu8d_pkg::result_t res,
  input  logic               result_ready,
  output logic               free,
  output logic               result_valid,
  output logic [15:0]        code_unit,
  output logic [1:0]         kind,
  output logic               last
);
  import cmu8d_pkg::*;

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      code_unit <= res.code_unit;
      kind      <= res.kind;
      last      <= res.last;
    end
  end

endmodule

@@ design/chunked_modified_utf8_string_decoder.sv @@
// Top level of the chunked modified UTF-8 string decoder.
// Takes one byte per cycle on the data channel and gives each result in the
// cycle after its byte is taken; the decode state and the result register
// update in the same cycle, so bytes stream at one per clock. data_ready drops
// only while a held result is not being taken by result_ready. CHUNK_SIZE
// sets how many chunks a string length calls for; the remaining length is
// stepped down by CHUNK_SIZE at the end of each chunk.
module chunked_modified_utf8_string_decoder #(
  parameter int CHUNK_SIZE = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [15:0] code_unit,
  output logic [1:0]  kind,
  output logic        last
);
  import cmu8d_pkg::*;

  state_t  st;
  state_t  st_next;
  result_t res;
  logic    accept;
  logic    free;

  cmu8d_step #(
    .CHUNK_SIZE(CHUNK_SIZE)
  ) u_step (
    .st        (st),
    .data_byte (data_byte),
    .st_next   (st_next),
    .res       (res)
  );

  cmu8d_outreg u_outreg (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && res.valid),
    .res          (res),
    .result_ready (result_ready),
    .free         (free),
    .result_valid (result_valid),
    .code_unit    (code_unit),
    .kind         (kind),
    .last         (last)
  );

  assign data_ready = free;
  assign accept     = data_valid && data_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

`ifndef ASSERT_OFF
  a_null_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_NULL) |-> last)
    else $error("null string item without last");

  a_nonchar_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind != KIND_CHAR) |-> (code_unit == 16'd0))
    else $error("non-character item carries a code unit");

  a_null_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && st.phase == PH_NULL && data_byte != 8'd0) |=>
      (result_valid && kind == KIND_NULL))
    else $error("nonzero null flag gave no null string item");

  a_cont_in_data: assert property (@(posedge clk) disable iff (rst)
    (st.continuations_needed != 2'd0) |-> (st.phase == PH_DATA))
    else $error("pending continuation outside data phase");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !data_ready |-> (result_valid && !result_ready))
    else $error("input stalled without a held result");
`endif

endmodule
